>>> rtl/core/rotated_edge_potential_projection_unit_defines.svh
// Assertion macros shared by the projection unit.
`ifndef ROTATED_EDGE_POTENTIAL_PROJECTION_UNIT_DEFINES_SVH
`define ROTATED_EDGE_POTENTIAL_PROJECTION_UNIT_DEFINES_SVH
// Assert that an antecedent implies a consequent in the same cycle.
`define REPP_ASSERT_IMP(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |-> (c)) else $error(msg);
// Assert that an antecedent implies a consequent in the next cycle.
`define REPP_ASSERT_NXT(label, clk, rst, a, c, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (a) |=> (c)) else $error(msg);
`endif

>>> rtl/core/repp_pkg.sv
// Types, constants and helpers of the projection unit.
package repp_pkg;
   localparam int QUEUE_DEPTH = 4;
   localparam logic [1:0] KIND_VALUE = 2'd0;
   localparam logic [1:0] KIND_DMU   = 2'd1;
   localparam logic [1:0] KIND_DTH   = 2'd2;
   localparam logic [2:0] REG_MU = 3'd0;
   localparam logic [2:0] REG_SIN = 3'd1;
   localparam logic [2:0] REG_COS = 3'd2;
   localparam logic [2:0] REG_AX = 3'd3;
   localparam logic [2:0] REG_AY = 3'd4;
   localparam logic [2:0] REG_AZ = 3'd5;
   localparam logic signed [31:0] ONE_Q30 = 32'sd1073741824;

   typedef struct packed {
      logic               theta;
      logic               scale;
      logic signed [32:0] mx;
      logic signed [32:0] my;
      logic signed [32:0] mz;
      logic signed [31:0] ex;
      logic signed [31:0] ey;
      logic signed [31:0] ez;
   } item_type;

   function automatic logic signed [31:0] clamp_unit(input logic signed [31:0] v);
      if (v > ONE_Q30) return ONE_Q30;
      if (v < -ONE_Q30) return -ONE_Q30;
      return v;
   endfunction

   // Round a Q30 product back by adding one half and flooring.
   function automatic logic signed [35:0] rnd30(input logic signed [67:0] v);
      logic signed [67:0] t;
      t = v + 68'sd536870912;
      return t[65:30];
   endfunction
endpackage

>>> rtl/core/repp_front.sv
// Front end: accepts requests, forms the midpoint and decodes the kind.
module repp_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  logic [1:0]          kind,
   input  logic signed [31:0]  ax, ay, az, bx, by, bz, ex, ey, ez,
   output logic                out_valid,
   input  logic                out_stall,
   output repp_pkg::item_type  out_item
);
   import repp_pkg::*;
   logic     valid_ff, valid_in;
   item_type item_ff, item_in;
   logic signed [32:0] sx, sy, sz;

   assign in_stall = valid_ff && out_stall;
   always_comb begin
      sx = 33'(ax) + 33'(bx);
      sy = 33'(ay) + 33'(by);
      sz = 33'(az) + 33'(bz);
      item_in.theta = (kind == KIND_DTH);
      item_in.scale = (kind != KIND_DMU);
      item_in.mx = sx >>> 1;
      item_in.my = sy >>> 1;
      item_in.mz = sz >>> 1;
      item_in.ex = ex;
      item_in.ey = ey;
      item_in.ez = ez;
      valid_in = in_stall ? valid_ff : in_valid;
   end
   always_ff @(posedge clock) begin
      if (reset) valid_ff <= 1'b0;
      else valid_ff <= valid_in;
      if (!in_stall) item_ff <= item_in;
   end
   assign out_valid = valid_ff;
   assign out_item = item_ff;
endmodule

>>> rtl/core/repp_queue.sv
// Short queue between front and back ends.
module repp_queue #(parameter int DEPTH = repp_pkg::QUEUE_DEPTH) (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  repp_pkg::item_type in_item,
   output logic               out_valid,
   input  logic               out_stall,
   output repp_pkg::item_type out_item
);
   import repp_pkg::*;
   localparam int AW = $clog2(DEPTH);
   item_type mem_ff [DEPTH];
   logic [AW:0] count_ff, count_in;
   logic [AW-1:0] wp_ff, rp_ff;
   logic push, pop;

   assign in_stall = (count_ff == (AW+1)'(DEPTH));
   assign out_valid = (count_ff != '0);
   assign out_item = mem_ff[rp_ff];
   assign push = in_valid && !in_stall;
   assign pop = out_valid && !out_stall;
   always_comb count_in = count_ff + (AW+1)'(push) - (AW+1)'(pop);
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0; wp_ff <= '0; rp_ff <= '0;
      end else begin
         count_ff <= count_in;
         if (push) wp_ff <= (wp_ff == AW'(DEPTH-1)) ? '0 : wp_ff + 1'b1;
         if (pop) rp_ff <= (rp_ff == AW'(DEPTH-1)) ? '0 : rp_ff + 1'b1;
      end
      if (push) mem_ff[wp_ff] <= in_item;
   end
endmodule

>>> rtl/core/repp_back.sv
// Back end: rotation, dot product and mu scaling in a stalling pipeline.
`include "rotated_edge_potential_projection_unit_defines.svh"
module repp_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  repp_pkg::item_type  in_item,
   input  logic signed [31:0]  mu, sn, cs, ux, uy, uz,
   output logic                out_valid,
   input  logic                out_stall,
   output logic signed [63:0]  projection,
   output logic                saturated
);
   import repp_pkg::*;
   localparam int NS = 12;
   logic [NS-1:0] v_ff;
   logic adv;
   logic signed [31:0] s, c;
   logic signed [31:0] u [3];
   logic signed [32:0] m_in [3];
   logic signed [31:0] e_in [3];

   // Stage 1: products of axis and midpoint.
   logic t1_ff, sc1_ff;
   logic signed [32:0] m1_ff [3];
   logic signed [31:0] e1_ff [3];
   logic signed [65:0] um_ff [3][3];
   // Stage 2: rounded axis projection and cross product.
   logic t2_ff, sc2_ff;
   logic signed [32:0] m2_ff [3];
   logic signed [31:0] e2_ff [3];
   logic signed [35:0] dq2_ff;
   logic signed [35:0] x2_ff [3];
   // Stage 3: axis scaled by the projection.
   logic t3_ff, sc3_ff;
   logic signed [32:0] m3_ff [3];
   logic signed [31:0] e3_ff [3];
   logic signed [35:0] x3_ff [3];
   logic signed [67:0] pp3_ff [3];
   // Stage 4: rounded parallel part and the first two trig products.
   logic t4_ff, sc4_ff;
   logic signed [31:0] e4_ff [3];
   logic signed [35:0] p4_ff [3];
   logic signed [67:0] a4_ff [3], b4_ff [3];
   // Stage 5: trig product of the parallel part.
   logic t5_ff, sc5_ff;
   logic signed [31:0] e5_ff [3];
   logic signed [35:0] p5_ff [3], ra5_ff [3], rb5_ff [3];
   logic signed [67:0] d5_ff [3];
   // Stage 6: rotated vector.
   logic sc6_ff;
   logic signed [31:0] e6_ff [3];
   logic signed [37:0] r6_ff [3];
   // Stages 7 to 9: dot product and its saturation.
   logic sc7_ff;
   logic signed [69:0] pr7_ff [3];
   logic sc8_ff;
   logic signed [71:0] acc8_ff;
   logic sc9_ff, sat9_ff;
   logic signed [63:0] dot9_ff;
   // Stages 10 and 11: mu product split into two halves.
   logic sc10_ff, sat10_ff;
   logic signed [63:0] dot10_ff;
   logic signed [64:0] ml10_ff;
   logic signed [63:0] mh10_ff;
   logic sc11_ff, sat11_ff;
   logic signed [63:0] dot11_ff;
   logic signed [95:0] mp11_ff;
   // Stage 12: result.
   logic signed [63:0] res_ff;
   logic satr_ff;

   logic signed [35:0] r_dq;
   logic signed [35:0] r_x [3];
   logic signed [37:0] r_val [3];
   logic signed [63:0] dsat;
   logic dclip;
   logic signed [95:0] mr;
   logic signed [79:0] msh;
   logic signed [63:0] rsat;
   logic rclip;
   logic [64:0] out_word;
   logic plain_unclipped;

   assign s = clamp_unit(sn);
   assign c = clamp_unit(cs);
   assign u[0] = clamp_unit(ux);
   assign u[1] = clamp_unit(uy);
   assign u[2] = clamp_unit(uz);
   assign adv = !(v_ff[NS-1] && out_stall);
   assign in_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else if (adv) v_ff <= {v_ff[NS-2:0], in_valid};
   end

   always_comb begin
      m_in[0] = in_item.mx; m_in[1] = in_item.my; m_in[2] = in_item.mz;
      e_in[0] = in_item.ex; e_in[1] = in_item.ey; e_in[2] = in_item.ez;
      r_dq = rnd30(68'(um_ff[0][0]) + 68'(um_ff[1][1]) + 68'(um_ff[2][2]));
      r_x[0] = rnd30(68'(um_ff[1][2]) - 68'(um_ff[2][1]));
      r_x[1] = rnd30(68'(um_ff[2][0]) - 68'(um_ff[0][2]));
      r_x[2] = rnd30(68'(um_ff[0][1]) - 68'(um_ff[1][0]));
      for (int i = 0; i < 3; i++) begin
         if (t5_ff)
            r_val[i] = -38'(ra5_ff[i]) + 38'(rb5_ff[i]) + 38'(rnd30(d5_ff[i]));
         else
            r_val[i] = 38'(ra5_ff[i]) + 38'(rb5_ff[i]) + 38'(p5_ff[i])
                       - 38'(rnd30(d5_ff[i]));
      end
      dclip = (acc8_ff[71:63] != {9{acc8_ff[63]}});
      dsat = dclip ? (acc8_ff[71] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : acc8_ff[63:0];
      mr = mp11_ff + 96'sd32768;
      msh = mr[95:16];
      rclip = (msh[79:63] != {17{msh[63]}});
      rsat = rclip ? (msh[79] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}}) : msh[63:0];
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         t1_ff <= in_item.theta; sc1_ff <= in_item.scale;
         m1_ff <= m_in; e1_ff <= e_in;
         for (int i = 0; i < 3; i++)
            for (int j = 0; j < 3; j++) um_ff[i][j] <= 66'(u[i]) * 66'(m_in[j]);
         t2_ff <= t1_ff; sc2_ff <= sc1_ff; m2_ff <= m1_ff; e2_ff <= e1_ff;
         dq2_ff <= r_dq; x2_ff <= r_x;
         t3_ff <= t2_ff; sc3_ff <= sc2_ff; m3_ff <= m2_ff; e3_ff <= e2_ff;
         x3_ff <= x2_ff;
         t4_ff <= t3_ff; sc4_ff <= sc3_ff; e4_ff <= e3_ff;
         t5_ff <= t4_ff; sc5_ff <= sc4_ff; e5_ff <= e4_ff; p5_ff <= p4_ff;
         sc6_ff <= sc5_ff; e6_ff <= e5_ff; r6_ff <= r_val;
         sc7_ff <= sc6_ff;
         sc8_ff <= sc7_ff;
         acc8_ff <= 72'(pr7_ff[0]) + 72'(pr7_ff[1]) + 72'(pr7_ff[2]);
         sc9_ff <= sc8_ff; sat9_ff <= dclip; dot9_ff <= dsat;
         sc10_ff <= sc9_ff; sat10_ff <= sat9_ff; dot10_ff <= dot9_ff;
         ml10_ff <= 65'(mu) * 65'($signed({1'b0, dot9_ff[31:0]}));
         mh10_ff <= 64'(mu) * 64'($signed(dot9_ff[63:32]));
         sc11_ff <= sc10_ff; sat11_ff <= sat10_ff; dot11_ff <= dot10_ff;
         mp11_ff <= (96'(mh10_ff) <<< 32) + 96'(ml10_ff);
         res_ff <= sc11_ff ? rsat : dot11_ff;
         satr_ff <= sat11_ff | (sc11_ff & rclip);
         for (int i = 0; i < 3; i++) begin
            pp3_ff[i] <= 68'(u[i]) * 68'(dq2_ff);
            p4_ff[i] <= rnd30(pp3_ff[i]);
            a4_ff[i] <= 68'(t3_ff ? s : c) * 68'(m3_ff[i]);
            b4_ff[i] <= 68'(t3_ff ? c : s) * 68'(x3_ff[i]);
            ra5_ff[i] <= rnd30(a4_ff[i]);
            rb5_ff[i] <= rnd30(b4_ff[i]);
            d5_ff[i] <= 68'(t4_ff ? s : c) * 68'(p4_ff[i]);
            pr7_ff[i] <= 70'(e6_ff[i]) * 70'(r6_ff[i]);
         end
      end
   end

   assign out_valid = v_ff[NS-1];
   assign projection = res_ff;
   assign saturated = satr_ff;
   assign out_word = {satr_ff, res_ff};
   assign plain_unclipped = v_ff[NS-2] && adv && !sc11_ff && !sat11_ff;

   `REPP_ASSERT_IMP(a_stall_only_full, clock, reset, in_stall, out_valid, "stall without result")
   `REPP_ASSERT_NXT(a_hold, clock, reset, out_valid && out_stall, out_valid && $stable(out_word), "result lost")
   `REPP_ASSERT_NXT(a_unscaled_nosat, clock, reset, plain_unclipped, !satr_ff, "bad flag")
endmodule

>>> rtl/core/rotated_edge_potential_projection_unit.sv
// Rotated edge potential projection unit, top level.
// A request passes the front end register, the queue and the back end pipeline in turn.
// Throughput: one request per cycle while the result side does not stall, set by the fully pipelined multiplier stages.
// A four entry queue parts the front end from the back end pipeline.
// Reset is synchronous and active high; it clears valids and loads register defaults.
// The user must write registers only while the unit is idle; the unit does not enforce this.
module rotated_edge_potential_projection_unit #(
   parameter int QUEUE_DEPTH = repp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pot_a_x, req_pot_a_y, req_pot_a_z,
   input  logic signed [31:0] req_pot_b_x, req_pot_b_y, req_pot_b_z,
   input  logic signed [31:0] req_edge_x, req_edge_y, req_edge_z,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_projection,
   output logic               rsp_saturated,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data
);
   import repp_pkg::*;
   // Configuration registers, always ready.
   logic signed [31:0] mu_ff, sin_ff, cos_ff, ax_ff, ay_ff, az_ff;
   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         mu_ff <= 32'sd65536; sin_ff <= '0; cos_ff <= ONE_Q30;
         ax_ff <= '0; ay_ff <= '0; az_ff <= ONE_Q30;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_MU:  mu_ff <= csr_data;
            REG_SIN: sin_ff <= csr_data;
            REG_COS: cos_ff <= csr_data;
            REG_AX:  ax_ff <= csr_data;
            REG_AY:  ay_ff <= csr_data;
            REG_AZ:  az_ff <= csr_data;
            default: ;
         endcase
      end
   end

   logic f_valid, f_stall, q_valid, q_stall;
   item_type f_item, q_item;

   repp_front u_front (
      .clock, .reset, .in_valid(req_valid), .in_stall(req_stall), .kind(req_kind),
      .ax(req_pot_a_x), .ay(req_pot_a_y), .az(req_pot_a_z),
      .bx(req_pot_b_x), .by(req_pot_b_y), .bz(req_pot_b_z),
      .ex(req_edge_x), .ey(req_edge_y), .ez(req_edge_z),
      .out_valid(f_valid), .out_stall(f_stall), .out_item(f_item));

   repp_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
      .clock, .reset, .in_valid(f_valid), .in_stall(f_stall), .in_item(f_item),
      .out_valid(q_valid), .out_stall(q_stall), .out_item(q_item));

   repp_back u_back (
      .clock, .reset, .in_valid(q_valid), .in_stall(q_stall), .in_item(q_item),
      .mu(mu_ff), .sn(sin_ff), .cs(cos_ff), .ux(ax_ff), .uy(ay_ff), .uz(az_ff),
      .out_valid(rsp_valid), .out_stall(rsp_stall),
      .projection(rsp_projection), .saturated(rsp_saturated));
endmodule

>>> test/repp_projection_checker.sv
// Checker that predicts and compares each result of the projection unit.
module repp_projection_checker
   import repp_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic [1:0]         req_kind,
   input  logic signed [31:0] req_pot_a_x, req_pot_a_y, req_pot_a_z,
   input  logic signed [31:0] req_pot_b_x, req_pot_b_y, req_pot_b_z,
   input  logic signed [31:0] req_edge_x, req_edge_y, req_edge_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic signed [63:0] rsp_projection,
   input  logic               rsp_saturated,
   input  logic               csr_valid,
   input  logic               csr_ready,
   input  logic [2:0]         csr_index,
   input  logic [31:0]        csr_data,
   output int                 mismatches,
   output int                 outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic signed [127:0] wide_t;
   typedef struct {
      logic signed [63:0] projection;
      logic               saturated;
   } projection_t;

   localparam wide_t UNIT = 128'sd1073741824;
   localparam wide_t MAX64 = 128'sh7FFFFFFFFFFFFFFF;
   localparam wide_t MIN64 = -128'sh8000000000000000;

   logic signed [31:0] mu_gain, sin_angle, cos_angle, axis_x, axis_y, axis_z;
   projection_t        expected_q[$];

   function automatic wide_t unit_limit(logic signed [31:0] raw);
      wide_t v;
      v = raw;
      if (v > UNIT) return UNIT;
      if (v < -UNIT) return -UNIT;
      return v;
   endfunction

   function automatic wide_t round_q30(wide_t v);
      return (v + (128'sd1 <<< 29)) >>> 30;
   endfunction

   function automatic wide_t clip64(wide_t v, ref logic clipped);
      if (v > MAX64) begin
         clipped = 1'b1;
         return MAX64;
      end
      if (v < MIN64) begin
         clipped = 1'b1;
         return MIN64;
      end
      return v;
   endfunction

   function automatic projection_t project_edge(
      logic [1:0] kind,
      logic signed [31:0] a[3], logic signed [31:0] b[3], logic signed [31:0] e[3]);
      wide_t       s, c, mu, dq, dot, res, wa, wb;
      wide_t       u[3], m[3], x[3], p[3], r[3];
      logic        clipped;
      projection_t out;
      clipped = 1'b0;
      s = unit_limit(sin_angle);
      c = unit_limit(cos_angle);
      mu = mu_gain;
      u[0] = unit_limit(axis_x);
      u[1] = unit_limit(axis_y);
      u[2] = unit_limit(axis_z);
      for (int i = 0; i < 3; i++) begin
         wa = a[i];
         wb = b[i];
         m[i] = (wa + wb) >>> 1;
      end
      dq = round_q30(u[0] * m[0] + u[1] * m[1] + u[2] * m[2]);
      x[0] = round_q30(u[1] * m[2] - u[2] * m[1]);
      x[1] = round_q30(u[2] * m[0] - u[0] * m[2]);
      x[2] = round_q30(u[0] * m[1] - u[1] * m[0]);
      for (int i = 0; i < 3; i++) begin
         p[i] = round_q30(u[i] * dq);
         if (kind == KIND_DTH) begin
            r[i] = -round_q30(s * m[i]) + round_q30(c * x[i]) + round_q30(s * p[i]);
         end else begin
            r[i] = round_q30(c * m[i]) + round_q30(s * x[i]) + p[i] - round_q30(c * p[i]);
         end
      end
      wa = e[0];
      wb = e[1];
      dot = wa * r[0] + wb * r[1];
      wa = e[2];
      dot = clip64(dot + wa * r[2], clipped);
      if (kind == KIND_DMU) begin
         res = dot;
      end else begin
         res = clip64((mu * dot + (128'sd1 <<< 15)) >>> 16, clipped);
      end
      out.projection = res[63:0];
      out.saturated = clipped;
      return out;
   endfunction

   always @(posedge clock) begin
      projection_t want;
      if (reset) begin
         mu_gain <= 32'sd65536;
         sin_angle <= 32'sd0;
         cos_angle <= ONE_Q30;
         axis_x <= 32'sd0;
         axis_y <= 32'sd0;
         axis_z <= ONE_Q30;
         expected_q.delete();
         mismatches = 0;
      end else begin
         if (csr_valid && csr_ready) begin
            case (csr_index)
               REG_MU: mu_gain <= csr_data;
               REG_SIN: sin_angle <= csr_data;
               REG_COS: cos_angle <= csr_data;
               REG_AX: axis_x <= csr_data;
               REG_AY: axis_y <= csr_data;
               REG_AZ: axis_z <= csr_data;
               default: ;
            endcase
         end
         if (req_valid && !req_stall) begin
            expected_q.push_back(project_edge(req_kind,
               '{req_pot_a_x, req_pot_a_y, req_pot_a_z},
               '{req_pot_b_x, req_pot_b_y, req_pot_b_z},
               '{req_edge_x, req_edge_y, req_edge_z}));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               $display("%0t: unexpected result projection %h saturated %b",
                        $realtime, rsp_projection, rsp_saturated);
               mismatches++;
            end else begin
               want = expected_q.pop_front();
               if (rsp_projection !== want.projection) begin
                  $display("%0t: projection expected %h actual %h",
                           $realtime, want.projection, rsp_projection);
                  mismatches++;
               end
               if (rsp_saturated !== want.saturated) begin
                  $display("%0t: saturated expected %b actual %b",
                           $realtime, want.saturated, rsp_saturated);
                  mismatches++;
               end
            end
         end
      end
      outstanding = expected_q.size();
   end

   initial begin
      mismatches = 0;
      outstanding = 0;
   end
endmodule

>>> test/tb_rotated_edge_potential_projection_unit.sv
// Testbench top of the rotated edge potential projection unit.
module tb_rotated_edge_potential_projection_unit;
   import repp_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   logic [1:0]         req_kind = KIND_VALUE;
   logic signed [31:0] req_pot_a_x = '0, req_pot_a_y = '0, req_pot_a_z = '0;
   logic signed [31:0] req_pot_b_x = '0, req_pot_b_y = '0, req_pot_b_z = '0;
   logic signed [31:0] req_edge_x = '0, req_edge_y = '0, req_edge_z = '0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   logic signed [63:0] rsp_projection;
   logic               rsp_saturated;
   logic               csr_valid = 1'b0;
   logic               csr_ready;
   logic [2:0]         csr_index = REG_MU;
   logic [31:0]        csr_data = '0;
   int                 mismatches;
   int                 outstanding;
   // While set, neither side inserts idle cycles, so the pipeline runs flat out.
   logic               no_gaps = 1'b0;

   always #5 clock = ~clock;

   rotated_edge_potential_projection_unit i_dut (.*);

   repp_projection_checker i_checker (.*);

   // The result side stalls at random on its own, changing only at the falling edge.
   initial begin
      forever begin
         @(negedge clock);
         rsp_stall = !no_gaps && ($urandom_range(99) < 14);
      end
   end

   // Sends one request, with occasional idle cycles ahead of it, and returns
   // once it has been accepted. Entered and left at a falling edge.
   task automatic send_request(logic [1:0] kind,
                               logic signed [31:0] a[3], logic signed [31:0] b[3],
                               logic signed [31:0] e[3]);
      logic stalled;
      while (!no_gaps && $urandom_range(99) < 14) begin
         req_valid = 1'b0;
         @(negedge clock);
      end
      req_valid = 1'b1;
      req_kind = kind;
      {req_pot_a_x, req_pot_a_y, req_pot_a_z} = {a[0], a[1], a[2]};
      {req_pot_b_x, req_pot_b_y, req_pot_b_z} = {b[0], b[1], b[2]};
      {req_edge_x, req_edge_y, req_edge_z} = {e[0], e[1], e[2]};
      do begin
         @(posedge clock);
         stalled = req_stall;
      end while (stalled);
      @(negedge clock);
   endtask

   // Registers may only change with the unit empty: wait for every result,
   // then let the pipeline drain a little further.
   task automatic wait_idle();
      req_valid = 1'b0;
      while (outstanding != 0) @(negedge clock);
      repeat (20) @(negedge clock);
   endtask

   task automatic write_register(logic [2:0] index, logic [31:0] value);
      logic ready;
      csr_valid = 1'b1;
      csr_index = index;
      csr_data = value;
      do begin
         @(posedge clock);
         ready = csr_ready;
      end while (!ready);
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Field values lean towards the extremes and small magnitudes, where the
   // rounding and the saturation are most likely to go wrong.
   function automatic logic signed [31:0] random_word();
      case ($urandom_range(5))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2: return $signed($urandom_range(4095)) - 32'sd2048;
         3: return $signed($urandom) >>> 6;
         default: return $urandom;
      endcase
   endfunction

   // Trig and axis values: mostly in range, sometimes out of range to be clamped.
   function automatic logic [31:0] random_unit();
      case ($urandom_range(5))
         0: return ONE_Q30;
         1: return -ONE_Q30;
         2: return $urandom;
         default: return $signed($urandom_range(32'h80000000)) - ONE_Q30;
      endcase
   endfunction

   function automatic logic [31:0] random_gain();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $signed($urandom_range(32'h0003FFFF)) - 32'sh00020000;
         default: return $signed($urandom) >>> 8;
      endcase
   endfunction

   initial begin
      logic signed [31:0] a[3], b[3], e[3];
      logic signed [31:0] extreme;
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed requests under the reset register values: every kind, including
      // the unused code, with all-zero, all-maximum and all-minimum fields, and
      // pairs of endpoints whose sum overflows 32 bits.
      for (int k = 0; k < 4; k++) begin
         for (int v = 0; v < 3; v++) begin
            extreme = (v == 0) ? 32'sd0 : (v == 1) ? 32'sh7FFFFFFF : 32'sh80000000;
            a = '{extreme, extreme, extreme};
            send_request(k[1:0], a, a, a);
         end
         a = '{32'sh7FFFFFFF, 32'sh80000000, 32'sd1};
         b = '{32'sh7FFFFFFF, 32'sh80000000, -32'sd1};
         e = '{32'sh80000000, 32'sh7FFFFFFF, 32'sh01000000};
         send_request(k[1:0], a, b, e);
      end
      // A negative odd sum checks the floor in the midpoint.
      a = '{-32'sd3, 32'sd3, -32'sd1};
      b = '{32'sd0, 32'sd0, 32'sd0};
      e = '{32'sh01000000, 32'sh01000000, 32'sh01000000};
      send_request(KIND_VALUE, a, b, e);

      // Each phase loads a full register set and then streams random edges.
      // The first phases take the register extremes, one of them beyond the
      // unit range so that the clamp is exercised, and one phase has no gaps.
      for (int phase = 0; phase < 8; phase++) begin
         wait_idle();
         case (phase)
            0: begin
               write_register(REG_MU, 32'h7FFFFFFF);
               write_register(REG_SIN, ONE_Q30);
               write_register(REG_COS, ONE_Q30);
               write_register(REG_AX, ONE_Q30);
               write_register(REG_AY, ONE_Q30);
               write_register(REG_AZ, ONE_Q30);
            end
            1: begin
               write_register(REG_MU, 32'h80000000);
               write_register(REG_SIN, -ONE_Q30);
               write_register(REG_COS, -ONE_Q30);
               write_register(REG_AX, -ONE_Q30);
               write_register(REG_AY, -ONE_Q30);
               write_register(REG_AZ, -ONE_Q30);
            end
            2: begin
               write_register(REG_MU, 32'd0);
               write_register(REG_SIN, 32'h7FFFFFFF);
               write_register(REG_COS, 32'h80000000);
               write_register(REG_AX, 32'h80000000);
               write_register(REG_AY, 32'h7FFFFFFF);
               write_register(REG_AZ, 32'd0);
            end
            default: begin
               write_register(REG_MU, random_gain());
               write_register(REG_SIN, random_unit());
               write_register(REG_COS, random_unit());
               write_register(REG_AX, random_unit());
               write_register(REG_AY, random_unit());
               write_register(REG_AZ, random_unit());
            end
         endcase
         no_gaps = (phase == 4);
         for (int n = 0; n < 225; n++) begin
            for (int i = 0; i < 3; i++) begin
               a[i] = random_word();
               b[i] = random_word();
               e[i] = random_word();
            end
            send_request(2'($urandom_range(3)), a, b, e);
         end
         no_gaps = 1'b0;
      end

      wait_idle();
      if (mismatches == 0) begin
         $display("rotated_edge_potential_projection_unit regression: pass");
      end else begin
         $display("rotated_edge_potential_projection_unit regression: fail");
      end
      $finish;
   end

   // Guard against a hang: the full run needs well under a tenth of this.
   initial begin
      #2ms;
      $display("rotated_edge_potential_projection_unit regression: fail");
      $finish;
   end
endmodule

>>> files.f
+incdir+rtl/core
rtl/core/repp_pkg.sv
rtl/core/repp_front.sv
rtl/core/repp_queue.sv
rtl/core/repp_back.sv
rtl/core/rotated_edge_potential_projection_unit.sv
test/repp_projection_checker.sv
test/tb_rotated_edge_potential_projection_unit.sv
